// ===== hdl/isc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isc_pkg
// Types and codes shared by the itemset support counter and its channels.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int unsigned CNT_W  = 11;
  localparam int unsigned ROW_IW = 10;
  localparam int unsigned MASK_W = 32;
  localparam int unsigned TGT_W  = 5;

  typedef struct packed {
    logic              command;
    logic [ROW_IW-1:0] row_index;
    logic [MASK_W-1:0] row_bits;
    logic [MASK_W-1:0] present_mask;
    logic [MASK_W-1:0] absent_mask;
    logic [TGT_W-1:0]  target_item;
    logic              target_value;
  } isc_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] antecedent_count;
    logic [CNT_W-1:0] rule_count;
    logic             was_query;
  } isc_out_t;

  typedef enum logic [1:0] {
    ISC_IDLE,
    ISC_SCAN,
    ISC_RESP
  } isc_state_t;

endpackage
`default_nettype wire

// ===== hdl/isc_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isc_in_if
// Command channel: valid/ready handshake carrying one write or query.
// ----------------------------------------------------------------------------
interface isc_in_if;
  logic             valid;
  logic             ready;
  isc_pkg::isc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/isc_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isc_out_if
// Result channel: valid/ready handshake carrying counts or a write ack.
// ----------------------------------------------------------------------------
interface isc_out_if;
  logic              valid;
  logic              ready;
  isc_pkg::isc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/itemset_support_counter_core.sv =====
`default_nettype none
// Write: earliest result transfer in the cycle after the input transfer.
// Query: the result follows a scan of limit rows in ISC_SCAN, then ISC_RESP,
//   limit = min(rows_in_use, MAX_ROWS); the scan reads one table row per cycle.
// One command in flight: ready is low from transfer until the result transfer, high again
//   the cycle after. Reset (rst_n, synchronous) clears the sequencer and rows_in_use;
//   table contents stay undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
// itemset_support_counter_core
// Transaction table with a row-serial scan that counts rows meeting a
// present/absent mask pair, and among them rows whose target bit matches.
// ----------------------------------------------------------------------------
module itemset_support_counter_core #(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned ITEMS    = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  isc_in_if.sink                          in_ch,
  isc_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [isc_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam int unsigned AW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CNT_MAX = (1 << isc_pkg::CNT_W) - 1;
  localparam int unsigned LIM_MAX = (MAX_ROWS > CNT_MAX) ? CNT_MAX : MAX_ROWS;

  // table RAM
  logic [ITEMS-1:0] mem [MAX_ROWS];
  logic [ITEMS-1:0] rd_row_r;

  isc_pkg::isc_state_t state_r, state_nxt;

  logic [isc_pkg::CNT_W-1:0] rows_in_use_r;
  logic [isc_pkg::CNT_W-1:0] limit_r, limit_nxt;
  logic [isc_pkg::CNT_W-1:0] scan_r, scan_nxt;
  logic [isc_pkg::CNT_W-1:0] ante_r, ante_nxt;
  logic [isc_pkg::CNT_W-1:0] rule_r, rule_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic                      was_q_r, was_q_nxt;
  logic [ITEMS-1:0]          pres_r, pres_nxt;
  logic [ITEMS-1:0]          abs_r, abs_nxt;
  logic [isc_pkg::TGT_W-1:0] tgt_r, tgt_nxt;
  logic                      tval_r, tval_nxt;

  logic                      in_xfer;
  logic                      wr_en;
  logic                      rd_en;
  logic                      scan_more;
  logic                      row_match;
  logic                      tgt_ok;
  logic                      tgt_bit;
  logic [63:0]               row_pad;
  logic [isc_pkg::CNT_W-1:0] limit_in;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign wr_en     = in_xfer && (in_ch.data.command == isc_pkg::CMD_WRITE) &&
                     (17'(in_ch.data.row_index) < 17'(MAX_ROWS));
  assign scan_more = scan_r < limit_r;
  assign rd_en     = (state_r == isc_pkg::ISC_SCAN) && scan_more;

  assign limit_in  = (rows_in_use_r > isc_pkg::CNT_W'(LIM_MAX)) ?
                     isc_pkg::CNT_W'(LIM_MAX) : rows_in_use_r;

  // match/count unit, one row per cycle
  assign row_pad   = 64'(rd_row_r);
  assign tgt_ok    = 7'(tgt_r) < 7'(ITEMS);
  assign tgt_bit   = tgt_ok && row_pad[{1'b0, tgt_r}];
  assign row_match = ((rd_row_r & pres_r) == pres_r) && ((rd_row_r & abs_r) == '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(in_ch.data.row_index)] <= ITEMS'(64'(in_ch.data.row_bits));
    end
    if (rd_en) begin
      rd_row_r <= mem[AW'(scan_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= isc_pkg::ISC_IDLE;
      rd_pend_r     <= 1'b0;
      rows_in_use_r <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (cfg_we) begin
        rows_in_use_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    scan_r  <= scan_nxt;
    ante_r  <= ante_nxt;
    rule_r  <= rule_nxt;
    was_q_r <= was_q_nxt;
    pres_r  <= pres_nxt;
    abs_r   <= abs_nxt;
    tgt_r   <= tgt_nxt;
    tval_r  <= tval_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    limit_nxt   = limit_r;
    scan_nxt    = scan_r;
    ante_nxt    = ante_r;
    rule_nxt    = rule_r;
    rd_pend_nxt = 1'b0;
    was_q_nxt   = was_q_r;
    pres_nxt    = pres_r;
    abs_nxt     = abs_r;
    tgt_nxt     = tgt_r;
    tval_nxt    = tval_r;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;

    unique case (state_r)
      isc_pkg::ISC_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          ante_nxt = '0;
          rule_nxt = '0;
          if (in_ch.data.command == isc_pkg::CMD_QUERY) begin
            limit_nxt = limit_in;
            scan_nxt  = '0;
            pres_nxt  = ITEMS'(64'(in_ch.data.present_mask));
            abs_nxt   = ITEMS'(64'(in_ch.data.absent_mask));
            tgt_nxt   = in_ch.data.target_item;
            tval_nxt  = in_ch.data.target_value;
            state_nxt = isc_pkg::ISC_SCAN;
          end else begin
            was_q_nxt = 1'b0;
            state_nxt = isc_pkg::ISC_RESP;
          end
        end
      end
      isc_pkg::ISC_SCAN: begin
        rd_pend_nxt = scan_more;
        if (scan_more) begin
          scan_nxt = scan_r + 1'b1;
        end
        // evaluate the row read last cycle
        if (rd_pend_r && row_match) begin
          ante_nxt = ante_r + 1'b1;
          if (tgt_bit == tval_r) begin
            rule_nxt = rule_r + 1'b1;
          end
        end
        if (!scan_more && !rd_pend_r) begin
          was_q_nxt = 1'b1;
          state_nxt = isc_pkg::ISC_RESP;
        end
      end
      isc_pkg::ISC_RESP: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          state_nxt = isc_pkg::ISC_IDLE;
        end
      end
      default: begin
        state_nxt = isc_pkg::ISC_IDLE;
      end
    endcase
  end

  assign out_ch.data.antecedent_count = ante_r;
  assign out_ch.data.rule_count       = rule_r;
  assign out_ch.data.was_query        = was_q_r;

endmodule
`default_nettype wire

// ===== sim/isc_support_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isc_support_checker
// Watches the command, result and register ports of the support counter.
// Keeps its own copy of the transaction table and of rows_in_use, works out
// the counts for every command transfer, and checks each result transfer
// field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module isc_support_checker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  isc_in_if                              cmd_mon,
  isc_out_if                             res_mon,
  input  wire logic                      cfg_we,
  input  wire logic [isc_pkg::CNT_W-1:0] cfg_wdata,
  output int unsigned                    fail_count,
  output int unsigned                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_ROWS = 1024;

  logic [isc_pkg::MASK_W-1:0] txn_rows [TABLE_ROWS];
  logic [isc_pkg::CNT_W-1:0]  scan_rows;
  isc_pkg::isc_out_t          expected_counts [$];

  // Counts over rows 0 .. rows_in_use-1; the scan saturates at the table depth.
  function automatic isc_pkg::isc_out_t count_support(isc_pkg::isc_in_t c);
    isc_pkg::isc_out_t          res;
    int unsigned                lim;
    logic [isc_pkg::MASK_W-1:0] row;
    res = '0;
    if (c.command == isc_pkg::CMD_WRITE) begin
      return res;
    end
    lim = (scan_rows > TABLE_ROWS) ? TABLE_ROWS : scan_rows;
    for (int unsigned r = 0; r < lim; r++) begin
      row = txn_rows[r];
      if ((row & c.present_mask) == c.present_mask && (row & c.absent_mask) == '0) begin
        res.antecedent_count = res.antecedent_count + 1'b1;
        if (row[c.target_item] == c.target_value) begin
          res.rule_count = res.rule_count + 1'b1;
        end
      end
    end
    res.was_query = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns isc_support_checker: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    isc_pkg::isc_out_t want;
    if (!rst_n) begin
      scan_rows = '0;
      expected_counts.delete();
    end else begin
      if (cfg_we) begin
        scan_rows = cfg_wdata;
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        expected_counts.insert(expected_counts.size(), count_support(cmd_mon.data));
        if (cmd_mon.data.command == isc_pkg::CMD_WRITE) begin
          txn_rows[cmd_mon.data.row_index] = cmd_mon.data.row_bits;
        end
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = expected_counts.pop_front();
          if (res_mon.data.antecedent_count !== want.antecedent_count) begin
            report_mismatch($sformatf("antecedent_count %0d, expected %0d",
                                      res_mon.data.antecedent_count, want.antecedent_count));
          end
          if (res_mon.data.rule_count !== want.rule_count) begin
            report_mismatch($sformatf("rule_count %0d, expected %0d",
                                      res_mon.data.rule_count, want.rule_count));
          end
          if (res_mon.data.was_query !== want.was_query) begin
            report_mismatch($sformatf("was_query %0b, expected %0b",
                                      res_mon.data.was_query, want.was_query));
          end
        end
      end
    end
    pending <= unsigned'(expected_counts.size());
  end

endmodule
`default_nettype wire

// ===== sim/tb_itemset_support_counter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_itemset_support_counter_core
// Drives writes and support queries into the counter core, sets rows_in_use
// between bursts while the core is idle, and throttles both channels in
// several idle/stall mixes. Checking is done by isc_support_checker.
// ----------------------------------------------------------------------------
module tb_itemset_support_counter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned FILL_ROWS   = 64;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [isc_pkg::CNT_W-1:0] cfg_wdata;
  int unsigned               fail_count;
  int unsigned               pending;
  int unsigned               cycles = 0;
  int unsigned               src_idle_pct = 0;
  int unsigned               snk_stall_pct = 0;

  isc_in_if  cmd_ch ();
  isc_out_if res_ch ();

  itemset_support_counter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  isc_support_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_mon    (cmd_ch),
    .res_mon    (res_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_itemset_support_counter_core: done, errors");
      $finish;
    end
  end

  function automatic isc_pkg::isc_in_t write_cmd(logic [isc_pkg::ROW_IW-1:0] idx,
                                                 logic [isc_pkg::MASK_W-1:0] bits);
    isc_pkg::isc_in_t c;
    c.command      = isc_pkg::CMD_WRITE;
    c.row_index    = idx;
    c.row_bits     = bits;
    c.present_mask = $urandom();
    c.absent_mask  = $urandom();
    c.target_item  = isc_pkg::TGT_W'($urandom());
    c.target_value = 1'($urandom());
    return c;
  endfunction

  function automatic isc_pkg::isc_in_t query_cmd(logic [isc_pkg::MASK_W-1:0] pres,
                                                 logic [isc_pkg::MASK_W-1:0] absm,
                                                 logic [isc_pkg::TGT_W-1:0] tgt, logic tval);
    isc_pkg::isc_in_t c;
    c.command      = isc_pkg::CMD_QUERY;
    c.row_index    = isc_pkg::ROW_IW'($urandom());
    c.row_bits     = $urandom();
    c.present_mask = pres;
    c.absent_mask  = absm;
    c.target_item  = tgt;
    c.target_value = tval;
    return c;
  endfunction

  // Mix of dense, sparse, full and empty rows so masks hit now and then.
  function automatic logic [isc_pkg::MASK_W-1:0] rand_row_bits();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom() | $urandom();
      2: return $urandom() | $urandom() | $urandom();
      3: return $urandom() & $urandom();
      4: return '1;
      default: return '0;
    endcase
  endfunction

  function automatic logic [isc_pkg::MASK_W-1:0] rand_mask();
    case ($urandom_range(0, 7))
      0, 1: return '0;
      2, 3: return $urandom() & $urandom() & $urandom();
      4: return $urandom() & $urandom() & $urandom() & $urandom();
      5: return 32'h1 << $urandom_range(0, 31);
      6: return $urandom() & $urandom();
      default: return $urandom();
    endcase
  endfunction

  // valid stays high across back-to-back transfers unless a gap is taken
  task automatic push_cmd(isc_pkg::isc_in_t c);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_rows_in_use(int unsigned n);
    cfg_we    <= 1'b1;
    cfg_wdata <= isc_pkg::CNT_W'(n);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    isc_pkg::isc_in_t c;
    int unsigned      src_mix [4];
    int unsigned      snk_mix [4];
    src_mix = '{0, 53, 0, 26};
    snk_mix = '{0, 0, 53, 26};
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rows_in_use still at reset value: nothing scanned
    push_cmd(query_cmd('0, '0, 5'd0, 1'b1));
    push_cmd(write_cmd(10'd0, 32'h0000_0000));
    push_cmd(write_cmd(10'd1, 32'hFFFF_FFFF));
    push_cmd(write_cmd(10'd2, 32'hAAAA_AAAA));
    push_cmd(write_cmd(10'd3, 32'h5555_5555));
    push_cmd(write_cmd(10'd4, 32'h8000_0001));
    push_cmd(write_cmd(10'd5, $urandom()));
    push_cmd(write_cmd(10'd1023, 32'hFFFF_FFFF));
    settle();
    set_rows_in_use(6);
    push_cmd(query_cmd('0, '0, 5'd0, 1'b1));
    push_cmd(query_cmd('1, '0, 5'd31, 1'b1));
    push_cmd(query_cmd('0, '1, 5'd31, 1'b0));
    // same item required present and absent: no row can match
    push_cmd(query_cmd(32'h0000_0001, 32'h0000_0001, 5'd0, 1'b1));
    push_cmd(query_cmd(32'hAAAA_AAAA, '0, 5'd1, 1'b0));
    push_cmd(query_cmd('0, 32'h8000_0000, 5'd0, 1'b1));
    push_cmd(query_cmd(32'h0000_0001, 32'h0000_0002, 5'd31, 1'b1));
    settle();
    set_rows_in_use(1);
    push_cmd(query_cmd('0, '0, 5'd31, 1'b0));

    // fill the low rows so every scan below reads written rows only
    src_idle_pct  = 26;
    snk_stall_pct = 26;
    for (int i = 0; i < FILL_ROWS; i++) begin
      push_cmd(write_cmd(isc_pkg::ROW_IW'(i), rand_row_bits()));
    end
    src_idle_pct  = 0;
    snk_stall_pct = 0;

    // scans over every filled row
    settle();
    set_rows_in_use(FILL_ROWS);
    push_cmd(query_cmd(rand_mask(), rand_mask(), isc_pkg::TGT_W'($urandom()),
                       1'($urandom())));
    push_cmd(query_cmd('0, '0, isc_pkg::TGT_W'($urandom()), 1'b1));

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = src_mix[ph];
      snk_stall_pct = snk_mix[ph];
      for (int blk = 0; blk < 5; blk++) begin
        settle();
        set_rows_in_use($urandom_range(0, FILL_ROWS));
        for (int n = 0; n < 25; n++) begin
          if ($urandom_range(0, 99) < 40) begin
            // most writes land in the low rows that small scans cover
            if ($urandom_range(0, 99) < 75) begin
              c = write_cmd(isc_pkg::ROW_IW'($urandom_range(0, FILL_ROWS - 1)),
                            rand_row_bits());
            end else begin
              c = write_cmd(isc_pkg::ROW_IW'($urandom()), rand_row_bits());
            end
          end else begin
            c = query_cmd(rand_mask(), rand_mask(), isc_pkg::TGT_W'($urandom()),
                          1'($urandom()));
          end
          push_cmd(c);
        end
      end
    end

    settle();
    repeat (1100) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_itemset_support_counter_core: done, clean");
    end else begin
      $display("tb_itemset_support_counter_core: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/isc_pkg.sv
hdl/isc_in_if.sv
hdl/isc_out_if.sv
hdl/itemset_support_counter_core.sv
sim/isc_support_checker.sv
sim/tb_itemset_support_counter_core.sv
